// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/sobel_pkg.sv =====
// shared types and constants for the sobel edge filter
`default_nettype none
package sobel_pkg;
    localparam int unsigned PIX_W = 24;
    localparam int unsigned CH_W  = 8;
    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;
    localparam logic [15:0] SAT_LIMIT = 16'd65280;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic top_zero;
        logic bot_zero;
        logic left_zero;
        logic right_zero;
        logic last;
    } t_edge;
endpackage
`default_nettype wire

// ===== rtl/core/sobel_stream_if.sv =====
// valid/ready stream interface carrying a packed payload
`default_nettype none
interface sobel_stream_if #(parameter int unsigned DATA_W = 24);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sobel_line_mem.sv =====
// two line stores in one memory and the read/modify/write of a column
`default_nettype none
module sobel_line_mem #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned ADDR_W    = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic [23:0]         i_pix,
    output logic [23:0]              o_top,
    output logic [23:0]              o_mid
);
    logic [47:0] mem [MAX_WIDTH];
    logic [47:0] r_rd;
    logic [47:0] r_fwd_data;
    logic        r_fwd;
    logic [23:0] r_pix;
    logic [ADDR_W-1:0] r_addr;
    logic        r_wb;
    logic [47:0] rd_eff;
    logic [47:0] wr_data;

    // a read of the column being written back in the same cycle takes the new data
    assign rd_eff  = r_fwd ? r_fwd_data : r_rd;
    assign wr_data = {rd_eff[23:0], r_pix};
    assign o_top   = rd_eff[47:24];
    assign o_mid   = rd_eff[23:0];

    // read on a transaction, write the shifted column back in the next cycle
    always_ff @(posedge i_clk) begin
        r_wb <= i_en;
        if (i_en) begin
            r_rd       <= mem[i_addr];
            r_fwd      <= r_wb && (i_addr == r_addr);
            r_fwd_data <= wr_data;
            r_pix      <= i_pix;
            r_addr     <= i_addr;
        end
        if (r_wb) begin
            mem[r_addr] <= wr_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/sobel_mag.sv =====
// per-channel sobel sums and rounded square root, pipelined
`default_nettype none
module sobel_mag (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_w [9],
    input  wire logic [3:0] i_mask,
    output logic [7:0]      o_mag
);
    // mask: top, bottom, left, right
    logic [7:0] v [9];
    logic signed [11:0] gx, gy;
    logic signed [11:0] r_gx, r_gy;
    logic [21:0] r_s;
    logic [7:0] r_n [9];
    logic [21:0] r_ss [9];
    logic [7:0] n_try;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = i_w[k];
            if ((k < 3 && i_mask[3]) || (k > 5 && i_mask[2]) ||
                (k % 3 == 0 && i_mask[1]) || (k % 3 == 2 && i_mask[0])) begin
                v[k] = 8'd0;
            end
        end
        gx = 12'(signed'({4'd0, v[2]})) - 12'(signed'({4'd0, v[0]}))
           + 12'(signed'({3'd0, v[5], 1'b0})) - 12'(signed'({3'd0, v[3], 1'b0}))
           + 12'(signed'({4'd0, v[8]})) - 12'(signed'({4'd0, v[6]}));
        gy = 12'(signed'({4'd0, v[6]})) - 12'(signed'({4'd0, v[0]}))
           + 12'(signed'({3'd0, v[7], 1'b0})) - 12'(signed'({3'd0, v[1], 1'b0}))
           + 12'(signed'({4'd0, v[8]})) - 12'(signed'({4'd0, v[2]}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx <= gx;
            r_gy <= gy;
            r_s  <= 22'(r_gx * r_gx) + 22'(r_gy * r_gy);
            r_ss[0] <= r_s;
            r_n[0]  <= 8'd0;
            // one result bit per stage
            for (int b = 0; b < 8; b++) begin
                r_ss[b+1] <= r_ss[b];
                if (({14'd0, r_n[b] | (8'd128 >> b)} * {14'd0, r_n[b] | (8'd128 >> b)})
                    <= r_ss[b]) begin
                    r_n[b+1] <= r_n[b] | (8'd128 >> b);
                end else begin
                    r_n[b+1] <= r_n[b];
                end
            end
        end
    end

    assign n_try = r_n[8];
    always_comb begin
        if (r_ss[8] > {6'd0, sobel_pkg::SAT_LIMIT}) begin
            o_mag = 8'd255;
        end else if (r_ss[8] > ({14'd0, n_try} * {14'd0, n_try} + {14'd0, n_try})) begin
            o_mag = n_try + 8'd1;
        end else begin
            o_mag = n_try;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude_rgb_top.sv =====
// Sobel edge magnitude filter on an RGB raster stream. Pixels enter at one per clock;
// each pixel's result leaves width+1 transactions later, passing through the window and
// gradient, square, root input, 8 root stages and output register. A result waiting at the
// output stalls the whole pipeline and the input with it.
// Both line stores share one 48-bit wide memory read and written once per transaction.
// Send width+1 filler transactions after each frame; writing a register restarts the frame.
`default_nettype none
`include "assert_macros.svh"
module sobel_edge_magnitude_rgb_top #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    sobel_stream_if.sink   s_in,
    sobel_stream_if.source m_out
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned DEPTH = 11;

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [13:0] r_col;
    logic [13:0] r_row;
    logic [13:0] w_eff, h_eff;
    logic        adv, fire;
    logic [23:0] pix, top, mid;
    logic [23:0] r_win [9];
    logic [23:0] win [9];
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_last;
    sobel_pkg::t_edge n_edge;
    logic [13:0] cr, cc;
    logic [7:0]  mag [3];
    logic [23:0] r_out;
    logic        r_out_last, r_out_vld;
    logic        r_fire_d;

    assign w_eff = (r_width == 11'd0) ? 14'd1 :
                   ({3'd0, r_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'd0, r_width};
    assign h_eff = (r_height == 13'd0) ? 14'd1 : {1'b0, r_height};

    // whole pipeline stalls while the output register is full and not taken
    assign adv  = !r_out_vld || m_out.ready;
    assign s_in.ready = adv;
    assign fire = s_in.valid && adv;
    assign pix  = (r_row < h_eff) ? s_in.data : 24'd0;

    sobel_line_mem #(.MAX_WIDTH(MAX_WIDTH), .ADDR_W(AW)) u_mem (
        .i_clk(i_clk), .i_en(fire), .i_addr(r_col[AW-1:0]), .i_pix(pix),
        .o_top(top), .o_mid(mid)
    );

    logic [23:0] r_pix_d;
    logic        r_emit_d;
    sobel_pkg::t_edge r_edge_d;
    logic        emit;
    always_comb begin
        emit = (r_row >= 14'd2) || (r_row == 14'd1 && r_col >= 14'd1);
        if (r_col == 14'd0) begin
            cc = w_eff - 14'd1; cr = r_row - 14'd2;
        end else begin
            cc = r_col - 14'd1; cr = r_row - 14'd1;
        end
        n_edge.top_zero   = (cr == 14'd0);
        n_edge.bot_zero   = (cr == h_eff - 14'd1);
        n_edge.left_zero  = (cc == 14'd0);
        n_edge.right_zero = (cc == w_eff - 14'd1);
        n_edge.last       = (r_row == h_eff + 14'd1) && (r_col == 14'd0);
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = r_win[r*3+1];
            win[r*3+1] = r_win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = r_pix_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd640;
            r_height <= 13'd480;
            r_col <= '0;
            r_row <= '0;
            r_vld <= '0;
            r_emit_d <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sobel_pkg::CFG_WIDTH) r_width <= i_cfg_data[10:0];
                else r_height <= i_cfg_data;
                r_col <= '0;
                r_row <= '0;
            end else if (fire) begin
                if (n_edge.last) begin
                    r_col <= '0; r_row <= '0;
                end else if (r_col + 14'd1 >= w_eff) begin
                    r_col <= '0; r_row <= r_row + 14'd1;
                end else begin
                    r_col <= r_col + 14'd1;
                end
            end
            if (adv) begin
                r_emit_d <= fire && emit;
                r_pix_d  <= pix;
                r_edge_d <= n_edge;
                r_vld <= {r_vld[DEPTH-2:0], r_emit_d};
                r_last <= {r_last[DEPTH-2:0], r_edge_d.last};
                r_out_vld <= r_vld[DEPTH-1];
                r_out <= {mag[2], mag[1], mag[0]};
                r_out_last <= r_last[DEPTH-1];
            end
            if (r_fire_d && adv) begin
                for (int k = 0; k < 9; k++) r_win[k] <= win[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fire_d <= 1'b0;
        else if (adv) r_fire_d <= fire;
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [7:0] cw [9];
        for (genvar k = 0; k < 9; k++) begin : g_tap
            assign cw[k] = win[k][ch*8 +: 8];
        end
        sobel_mag u_mag (
            .i_clk(i_clk), .i_en(adv), .i_w(cw),
            .i_mask({r_edge_d.top_zero, r_edge_d.bot_zero,
                     r_edge_d.left_zero, r_edge_d.right_zero}),
            .o_mag(mag[ch])
        );
    end

    assign m_out.valid = r_out_vld;
    assign m_out.data  = {r_out_last, r_out};

    `ASSERT_NEVER(a_no_fire_cfg, i_clk, i_rst_n, i_cfg_we && fire)
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, (r_out_vld && !m_out.ready) |=> r_out_vld)
    `ASSERT_IMPL(a_col_rng, i_clk, i_rst_n, 1'b1 |-> (r_col < w_eff || i_cfg_we || $past(i_cfg_we)))
endmodule
`default_nettype wire
